// ===== sv/ovds_pkg.sv =====
package ovds_pkg;

  localparam int OBJECT_BYTES = 160;
  localparam int BLOCK_BYTES  = 16;

  localparam int OBJ_IDX_W = (OBJECT_BYTES > 1) ? $clog2(OBJECT_BYTES) : 1;
  localparam int BLK_W     = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

  localparam logic [15:0] OBJ_BASE  = 16'hFE00;
  localparam logic [15:0] VRAM_BASE = 16'h8000;
  localparam logic [7:0]  BLOCKS_DONE = 8'hFF;

  typedef enum logic [2:0] {
    CMD_SET_SOURCE    = 3'd0,
    CMD_SET_TARGET    = 3'd1,
    CMD_START_GENERAL = 3'd2,
    CMD_START_HBLANK  = 3'd3,
    CMD_HBLANK_EVENT  = 3'd4,
    CMD_START_OBJECT  = 3'd5,
    CMD_TICK          = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_GENERAL = 2'd1,
    MODE_HBLANK  = 2'd2
  } mode_t;

  typedef enum logic {
    CHAN_OBJECT = 1'b0,
    CHAN_VIDEO  = 1'b1
  } chan_t;

  typedef struct packed {
    logic [15:0] source_address;
    logic [15:0] target_address;
    logic        channel;
    logic        last_of_transfer;
    logic [7:0]  blocks_remaining;
  } result_t;

endpackage

// ===== sv/ovds_if.sv =====
interface ovds_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface ovds_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] source_address;
  logic [15:0] target_address;
  logic        channel;
  logic        last_of_transfer;
  logic [7:0]  blocks_remaining;

  modport source (output valid, output source_address, output target_address,
                  output channel, output last_of_transfer, output blocks_remaining,
                  input ready);
  modport sink   (input valid, input source_address, input target_address,
                  input channel, input last_of_transfer, input blocks_remaining,
                  output ready);
endinterface

// ===== sv/ovds_core.sv =====
module ovds_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [2:0]          command,
  input  logic [15:0]         value,
  output logic                res_valid,
  output ovds_pkg::result_t   res
);
  import ovds_pkg::*;

  logic                 obj_active_r, obj_active_nxt;
  logic [7:0]           obj_page_r, obj_page_nxt;
  logic [OBJ_IDX_W-1:0] obj_index_r, obj_index_nxt;
  logic [15:0]          vid_source_r, vid_source_nxt;
  logic [15:0]          vid_target_r, vid_target_nxt;
  logic [7:0]           blocks_left_r, blocks_left_nxt;
  mode_t                mode_r, mode_nxt;
  logic [BLK_W-1:0]     block_byte_r, block_byte_nxt;
  logic                 block_armed_r, block_armed_nxt;

  logic [OBJ_IDX_W:0]   obj_index_inc;
  logic                 obj_last;
  logic [BLK_W:0]       block_byte_inc;
  logic                 block_end;
  logic [7:0]           blocks_dec;
  logic                 video_go;

  always_comb begin
    obj_index_inc  = {1'b0, obj_index_r} + 1'b1;
    obj_last       = (obj_index_inc >= (OBJ_IDX_W+1)'(OBJECT_BYTES));
    block_byte_inc = {1'b0, block_byte_r} + 1'b1;
    block_end      = (block_byte_inc >= (BLK_W+1)'(BLOCK_BYTES));
    blocks_dec     = blocks_left_r - 8'd1;
    video_go       = (mode_r == MODE_GENERAL) || ((mode_r == MODE_HBLANK) && block_armed_r);
  end

  always_comb begin
    obj_active_nxt  = obj_active_r;
    obj_page_nxt    = obj_page_r;
    obj_index_nxt   = obj_index_r;
    vid_source_nxt  = vid_source_r;
    vid_target_nxt  = vid_target_r;
    blocks_left_nxt = blocks_left_r;
    mode_nxt        = mode_r;
    block_byte_nxt  = block_byte_r;
    block_armed_nxt = block_armed_r;
    res_valid       = 1'b0;
    res             = '0;
    if (accept) begin
      unique case (command)
        CMD_SET_SOURCE: vid_source_nxt = value;
        CMD_SET_TARGET: vid_target_nxt = value;
        CMD_START_GENERAL, CMD_START_HBLANK: begin
          blocks_left_nxt = value[7:0];
          mode_nxt        = (command == CMD_START_GENERAL) ? MODE_GENERAL : MODE_HBLANK;
          block_byte_nxt  = '0;
          block_armed_nxt = 1'b0;
        end
        CMD_HBLANK_EVENT: begin
          if ((mode_r == MODE_HBLANK) && !block_armed_r) begin
            block_armed_nxt = 1'b1;
            block_byte_nxt  = '0;
          end
        end
        CMD_START_OBJECT: begin
          obj_page_nxt   = value[7:0];
          obj_index_nxt  = '0;
          obj_active_nxt = 1'b1;
        end
        CMD_TICK: begin
          // The object copy always wins the bus over the video copy.
          if (obj_active_r) begin
            res_valid                = 1'b1;
            res.source_address       = {obj_page_r, 8'd0} + 16'(obj_index_r);
            res.target_address       = OBJ_BASE + 16'(obj_index_r);
            res.channel              = CHAN_OBJECT;
            res.last_of_transfer     = obj_last;
            res.blocks_remaining     = blocks_left_r;
            obj_active_nxt           = !obj_last;
            obj_index_nxt            = obj_last ? '0 : obj_index_inc[OBJ_IDX_W-1:0];
          end else if (video_go) begin
            res_valid                = 1'b1;
            res.source_address       = vid_source_r;
            res.target_address       = VRAM_BASE + vid_target_r;
            res.channel              = CHAN_VIDEO;
            res.blocks_remaining     = blocks_left_r;
            vid_source_nxt           = vid_source_r + 16'd1;
            vid_target_nxt           = vid_target_r + 16'd1;
            block_byte_nxt           = block_byte_inc[BLK_W-1:0];
            if (block_end) begin
              block_byte_nxt       = '0;
              block_armed_nxt      = 1'b0;
              blocks_left_nxt      = blocks_dec;
              res.blocks_remaining = blocks_dec;
              res.last_of_transfer = (blocks_dec == BLOCKS_DONE) || (mode_r == MODE_HBLANK);
              if (blocks_dec == BLOCKS_DONE) begin
                mode_nxt = MODE_IDLE;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_active_r  <= 1'b0;
      obj_page_r    <= '0;
      obj_index_r   <= '0;
      vid_source_r  <= '0;
      vid_target_r  <= '0;
      blocks_left_r <= BLOCKS_DONE;
      mode_r        <= MODE_IDLE;
      block_byte_r  <= '0;
      block_armed_r <= 1'b0;
    end else begin
      obj_active_r  <= obj_active_nxt;
      obj_page_r    <= obj_page_nxt;
      obj_index_r   <= obj_index_nxt;
      vid_source_r  <= vid_source_nxt;
      vid_target_r  <= vid_target_nxt;
      blocks_left_r <= blocks_left_nxt;
      mode_r        <= mode_nxt;
      block_byte_r  <= block_byte_nxt;
      block_armed_r <= block_armed_nxt;
    end
  end

  a_obj_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, obj_index_r} < (OBJ_IDX_W+1)'(OBJECT_BYTES))
    else $error("object index beyond the copy length");

  a_idle_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !obj_active_r |-> (obj_index_r == '0))
    else $error("object index not cleared while the object copy is idle");

  a_armed_only_hblank: assert property (@(posedge clk) disable iff (!rst_n)
    block_armed_r |-> (mode_r == MODE_HBLANK))
    else $error("hblank block armed outside hblank mode");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.channel == CHAN_VIDEO && res.blocks_remaining == BLOCKS_DONE
     && res.last_of_transfer && mode_r == MODE_GENERAL) |=> (mode_r == MODE_IDLE))
    else $error("general copy did not return to idle after its last beat");
endmodule

// ===== sv/ovds_out_buf.sv =====
module ovds_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ovds_pkg::result_t push_data,
  output logic              space,
  ovds_out_if.source        out_ch
);
  import ovds_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r, out_data_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    pop;

  assign pop   = out_valid_r && out_ch.ready;
  assign space = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      // The output register is stalled, so the new beat parks in the skid stage.
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.source_address   = out_data_r.source_address;
  assign out_ch.target_address   = out_data_r.target_address;
  assign out_ch.channel          = out_data_r.channel;
  assign out_ch.last_of_transfer = out_data_r.last_of_transfer;
  assign out_ch.blocks_remaining = out_data_r.blocks_remaining;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a beat while the output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("beat pushed while both stages are full");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && pop) |=> (out_valid_r && !skid_valid_r))
    else $error("skid stage did not move forward after the output was taken");
endmodule

// ===== sv/object_and_video_dma_sequencer.sv =====
// A tick that has work passes its beat from the core into the output register, or into the skid stage.
// Throughput: one command per cycle while the skid stage is empty; a two-deep output register and skid stage keep
// input acceptance going while a single result beat waits to be taken.
// Reset is synchronous and active low: no copy active, addresses zero, block count 0xFF,
// video mode idle, and both output stages empty.
module object_and_video_dma_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  ovds_in_if.sink    in_ch,
  ovds_out_if.source out_ch
);
  import ovds_pkg::*;

  logic    accept;
  logic    space;
  logic    res_valid;
  result_t res;

  assign in_ch.ready = space;
  assign accept      = in_ch.valid && space;

  ovds_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .command   (in_ch.command),
    .value     (in_ch.value),
    .res_valid (res_valid),
    .res       (res)
  );

  ovds_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_ch    (out_ch)
  );
endmodule
